// ===== rtl/brot_pkg.sv =====
// ----------------------------------------------------------------------------
// brot_pkg
// Shared constants, types and codes of the strip-wise 90 degree bitmap rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package brot_pkg;

  // Source store geometry; ROW_ROUND_BITS must be a power of two
  localparam int MAX_WIDTH_BYTES = 64;
  localparam int MAX_HEIGHT      = 1024;
  localparam int ROW_ROUND_BITS  = 16;

  localparam int COL_W    = $clog2(MAX_WIDTH_BYTES);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_WIDTH_BYTES * MAX_HEIGHT;
  localparam int RND_W    = $clog2(ROW_ROUND_BITS);

  // Register fields
  localparam int WID_W    = 7;
  localparam int HGT_W    = 11;
  localparam int STRIP_W  = 7;
  localparam int DATA_W   = 11;
  localparam int IDX_W    = 2;

  // Output row length in bytes and row index within the rotated row
  localparam int BLK_W    = $clog2(MAX_HEIGHT / 8 + ROW_ROUND_BITS / 8 + 1);
  localparam int R_W      = BLK_W + 3;
  localparam int CMP_W    = (R_W > HGT_W) ? R_W : HGT_W;
  localparam int ROWS_W   = 10;

  localparam logic [2:0] BIT_LAST = 3'd7;

  typedef enum logic [IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_STRIP  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_LAST,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [WID_W-1:0]   eff_w;
    logic [HGT_W-1:0]   eff_h;
    logic [STRIP_W-1:0] strip_len;
    logic [BLK_W-1:0]   row_len;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              strip_end;
    logic [ROWS_W-1:0] strip_rows;
    logic              image_end;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/brot_ram.sv =====
// ----------------------------------------------------------------------------
// brot_ram
// Generic synchronous RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module brot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brot_cfg.sv =====
// ----------------------------------------------------------------------------
// brot_cfg
// Configuration registers, clamped working values and output row length.
// ----------------------------------------------------------------------------
`default_nettype none

module brot_cfg
  import brot_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [DATA_W-1:0] cfg_data_i,
  output logic                   restart_o,
  output cfg_t                   cfg_o
);

  logic [WID_W-1:0]   wid_q, wid_d;
  logic [HGT_W-1:0]   hgt_q, hgt_d;
  logic [STRIP_W-1:0] stp_q, stp_d;
  logic               restart_q, restart_d;
  logic               cfg_fire;
  logic [HGT_W-1:0]   neg_h;
  logic [RND_W-1:0]   pad_bits;
  logic [BLK_W-1:0]   blocks;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign restart_o   = restart_q;

  always_comb begin
    wid_d     = wid_q;
    hgt_d     = hgt_q;
    stp_d     = stp_q;
    restart_d = 1'b0;
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_WIDTH: begin
          wid_d     = cfg_data_i[WID_W-1:0];
          restart_d = 1'b1;
        end
        CFG_HEIGHT: begin
          hgt_d     = cfg_data_i[HGT_W-1:0];
          restart_d = 1'b1;
        end
        CFG_STRIP: begin
          stp_d     = cfg_data_i[STRIP_W-1:0];
          restart_d = 1'b1;
        end
        default: begin
          restart_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q     <= WID_W'(MAX_WIDTH_BYTES);
      hgt_q     <= HGT_W'(MAX_HEIGHT);
      stp_q     <= STRIP_W'(1);
      restart_q <= 1'b0;
    end else begin
      wid_q     <= wid_d;
      hgt_q     <= hgt_d;
      stp_q     <= stp_d;
      restart_q <= restart_d;
    end
  end

  always_comb begin
    if (wid_q == '0) begin
      cfg_o.eff_w = WID_W'(1);
    end else if (wid_q > WID_W'(MAX_WIDTH_BYTES)) begin
      cfg_o.eff_w = WID_W'(MAX_WIDTH_BYTES);
    end else begin
      cfg_o.eff_w = wid_q;
    end

    if (hgt_q == '0) begin
      cfg_o.eff_h = HGT_W'(1);
    end else if (hgt_q > HGT_W'(MAX_HEIGHT)) begin
      cfg_o.eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      cfg_o.eff_h = hgt_q;
    end

    cfg_o.strip_len = (stp_q == '0) ? STRIP_W'(1) : stp_q;

    blocks          = BLK_W'(({1'b0, cfg_o.eff_h} + (HGT_W + 1)'(7)) >> 3);
    neg_h           = HGT_W'(0) - cfg_o.eff_h;
    pad_bits        = neg_h[RND_W-1:0];
    cfg_o.row_len   = blocks + BLK_W'(pad_bits >> 3);
  end

endmodule

`default_nettype wire

// ===== rtl/brot_engine.sv =====
// ----------------------------------------------------------------------------
// brot_engine
// Read cursors, gather sequencer over the source store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brot_engine
  import brot_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cfg_t                  cfg_i,
  input  wire logic             restart_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             operation_i,
  input  wire logic [ROW_W-1:0] row_i,
  input  wire logic [COL_W-1:0] byte_column_i,
  input  wire logic [7:0]       pixel_byte_i,
  output mem_req_t              mem_req_o,
  input  wire logic [7:0]       mem_rdata_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output res_t                  out_o
);

  state_e             state_q, state_d;
  logic [2:0]         j_q, j_d;
  logic               cap_q, cap_d;
  logic [2:0]         cap_j_q, cap_j_d;
  logic [7:0]         byte_q, byte_d, byte_mrg;
  logic [COL_W-1:0]   col_q, col_d, col_start;
  logic [2:0]         bit_q, bit_d;
  logic [BLK_W-1:0]   blk_q, blk_d;
  logic [STRIP_W-1:0] sc_q, sc_d, sc_inc;
  res_t               hold_q, res_now;
  logic               out_valid_q;
  res_t               out_q;

  logic               in_fire, rd_fire, out_free;
  logic               issue, step, load_now, load_held;
  logic [2:0]         j_sel;
  logic [R_W-1:0]     row_sel;
  logic               row_hit, last_row, col_end, strip_hit, col_done;

  assign in_fire   = in_valid_i && in_ready_o;
  assign rd_fire   = in_fire && (operation_i == OP_READ);
  assign out_free  = !out_valid_q || out_ready_i;
  assign col_start = COL_W'(cfg_i.eff_w - WID_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rd_fire) state_d = ST_GATHER;
      end
      ST_GATHER: begin
        if (j_q == BIT_LAST) state_d = ST_LAST;
      end
      ST_LAST: begin
        state_d = out_free ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    step       = 1'b0;
    load_now   = 1'b0;
    load_held  = 1'b0;
    j_sel      = j_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !restart_i;
        issue      = rd_fire;
        j_sel      = 3'd0;
      end
      ST_GATHER: begin
        issue = 1'b1;
      end
      ST_LAST: begin
        step     = 1'b1;
        load_now = out_free;
      end
      ST_EMIT: begin
        load_held = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Store access
  always_comb begin
    row_sel         = {blk_q, j_sel};
    row_hit         = CMP_W'(row_sel) < CMP_W'(cfg_i.eff_h);
    mem_req_o.we    = in_fire && (operation_i == OP_LOAD);
    mem_req_o.waddr = {row_i, byte_column_i};
    mem_req_o.wdata = pixel_byte_i;
    mem_req_o.re    = issue && row_hit;
    mem_req_o.raddr = {row_sel[ROW_W-1:0], col_q};
  end

  // Gather: pick the cursor pixel out of each returned source byte
  always_comb begin
    byte_mrg = byte_q;
    if (cap_q) byte_mrg[~cap_j_q] = mem_rdata_i[~bit_q];
    byte_d  = rd_fire ? 8'd0 : byte_mrg;
    cap_d   = mem_req_o.re;
    cap_j_d = j_sel;
    j_d     = j_q;
    if (rd_fire) begin
      j_d = 3'd1;
    end else if (state_q == ST_GATHER) begin
      j_d = j_q + 3'd1;
    end
  end

  // Result flags and cursor advance
  always_comb begin
    last_row  = ({1'b0, blk_q} + (BLK_W + 1)'(1)) >= {1'b0, cfg_i.row_len};
    col_end   = (col_q == '0);
    col_done  = last_row && (bit_q == 3'd0);
    sc_inc    = sc_q + STRIP_W'(1);
    strip_hit = (sc_inc >= cfg_i.strip_len) || col_end;

    res_now.data       = byte_mrg;
    res_now.strip_end  = col_done && strip_hit;
    res_now.strip_rows = res_now.strip_end ? ROWS_W'({sc_inc, 3'b000}) : '0;
    res_now.image_end  = col_done && col_end;

    col_d = col_q;
    bit_d = bit_q;
    blk_d = blk_q;
    sc_d  = sc_q;
    if (restart_i) begin
      col_d = col_start;
      bit_d = BIT_LAST;
      blk_d = '0;
      sc_d  = '0;
    end else if (step) begin
      if (last_row) begin
        blk_d = '0;
        if (bit_q == 3'd0) begin
          bit_d = BIT_LAST;
          sc_d  = res_now.strip_end ? '0 : sc_inc;
          col_d = col_end ? col_start : col_q - COL_W'(1);
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end else begin
        blk_d = blk_q + BLK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      cap_q       <= 1'b0;
      cap_j_q     <= '0;
      col_q       <= COL_W'(MAX_WIDTH_BYTES - 1);
      bit_q       <= BIT_LAST;
      blk_q       <= '0;
      sc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      cap_q   <= cap_d;
      cap_j_q <= cap_j_d;
      col_q   <= col_d;
      bit_q   <= bit_d;
      blk_q   <= blk_d;
      sc_q    <= sc_d;
      if (load_now || load_held) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (step) hold_q <= res_now;
    if (load_now) begin
      out_q <= res_now;
    end else if (load_held) begin
      out_q <= hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/bitmap_rotate_ccw_strips.sv =====
// ----------------------------------------------------------------------------
// bitmap_rotate_ccw_strips
// Rotates a 1 bpp bitmap 90 degrees counterclockwise and delivers it in strips.
// ----------------------------------------------------------------------------
// A load transfer writes one source byte into a 64 KiB single-port-write store.
// A read transfer returns the next rotated byte: the block reads the eight
// source rows of that byte one after another from the store, which has one
// read port with a registered read, so the result enters the output register
// once the eight rows are gathered and the output is free, and the next
// transfer is taken in the cycle that result appears (padding bytes and rows
// past the height take the same time). The result sits in an output register
// and waits there for the consumer. A write to the width, height or strip
// register restarts reading at the first rotated byte, keeps the stored bitmap
// and holds the input off for the cycle after the write; write configuration
// only while no read is in flight.
`default_nettype none

module bitmap_rotate_ccw_strips
  import brot_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [DATA_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire logic [COL_W-1:0]  byte_column_i,
  input  wire logic [7:0]        pixel_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             rotated_byte_o,
  output logic                   strip_end_o,
  output logic [ROWS_W-1:0]      strip_rows_o,
  output logic                   image_end_o
);

  cfg_t     cfg;
  logic     restart;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;
  res_t     res;

  brot_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .restart_o   (restart),
    .cfg_o       (cfg)
  );

  brot_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  brot_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .restart_i     (restart),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .row_i         (row_i),
    .byte_column_i (byte_column_i),
    .pixel_byte_i  (pixel_byte_i),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_o         (res)
  );

  assign rotated_byte_o = res.data;
  assign strip_end_o    = res.strip_end;
  assign strip_rows_o   = res.strip_rows;
  assign image_end_o    = res.image_end;

endmodule

`default_nettype wire

// ===== tb/bitmap_rotate_ccw_strips_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_rotate_ccw_strips_tb
// Self-checking bench for the strip-wise 90 degree bitmap rotator. A local
// model of the source store, registers and read cursors predicts every rotated
// byte and its strip and image flags; a monitor compares each output transfer
// against the oldest prediction. Directed register sweeps, a long output stall
// and randomized image phases with random idling on both sides.
// ----------------------------------------------------------------------------
module bitmap_rotate_ccw_strips_tb;
  import brot_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index   = '0;
  logic [DATA_W-1:0] cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic              operation   = OP_LOAD;
  logic [ROW_W-1:0]  row         = '0;
  logic [COL_W-1:0]  byte_column = '0;
  logic [7:0]        pixel_byte  = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [7:0]        rotated_byte;
  logic              strip_end;
  logic [ROWS_W-1:0] strip_rows;
  logic              image_end;

  // local copy of the rotator
  logic [7:0]         src_mem [DEPTH];
  bit                 written [DEPTH];
  logic [WID_W-1:0]   width_reg;
  logic [HGT_W-1:0]   height_reg;
  logic [STRIP_W-1:0] strip_reg;
  logic [COL_W-1:0]   col_cur;
  logic [2:0]         bit_cur;
  logic [10:0]        blk_cur;
  logic [6:0]         strip_cnt;
  res_t               rotated_q [$];

  int unsigned err_cnt     = 0;
  int unsigned load_cnt    = 0;
  int unsigned read_cnt    = 0;
  int unsigned item_cnt    = 0;
  int unsigned cfg_cnt     = 0;
  int unsigned strips_seen = 0;
  int unsigned images_seen = 0;
  bit          no_idle;
  bit          hold_req;

  bitmap_rotate_ccw_strips u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .row_i          (row),
    .byte_column_i  (byte_column),
    .pixel_byte_i   (pixel_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .rotated_byte_o (rotated_byte),
    .strip_end_o    (strip_end),
    .strip_rows_o   (strip_rows),
    .image_end_o    (image_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamped_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_BYTES) return MAX_WIDTH_BYTES;
    return width_reg;
  endfunction

  function automatic int unsigned clamped_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void rewind_image();
    col_cur   = COL_W'(clamped_width() - 1);
    bit_cur   = BIT_LAST;
    blk_cur   = '0;
    strip_cnt = '0;
  endfunction

  function automatic res_t rotate_next();
    int unsigned h, blocks, row_len, slen, r, j;
    logic        last_in_row;
    res_t        res;
    h       = clamped_height();
    blocks  = (h + 7) / 8;
    row_len = blocks + (((h + ROW_ROUND_BITS - 1) / ROW_ROUND_BITS) * ROW_ROUND_BITS - h) / 8;
    slen    = (strip_reg == 0) ? 1 : strip_reg;
    res     = '0;
    if (blk_cur < blocks) begin
      for (j = 0; j < 8; j++) begin
        r = blk_cur * 8 + j;
        if (r < h) res.data[7-j] = src_mem[{ROW_W'(r), col_cur}][7-bit_cur];
      end
    end
    last_in_row = (blk_cur + 1 >= row_len);
    if (last_in_row && bit_cur == 0) begin
      strip_cnt++;
      if (strip_cnt >= slen || col_cur == 0) begin
        res.strip_end  = 1'b1;
        res.strip_rows = {strip_cnt, 3'b000};
        strip_cnt      = '0;
      end
      res.image_end = (col_cur == 0);
    end
    if (last_in_row) begin
      blk_cur = '0;
      if (bit_cur == 0) begin
        bit_cur = BIT_LAST;
        if (col_cur == 0) rewind_image();
        else col_cur--;
      end else begin
        bit_cur--;
      end
    end else begin
      blk_cur++;
    end
    return res;
  endfunction

  task automatic send_item(op_e op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c, logic [7:0] px);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(0, 99) < 25) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    row         <= r;
    byte_column <= c;
    pixel_byte  <= px;
    do @(posedge clk); while (!in_ready);
    item_cnt++;
    if (op == OP_LOAD) begin
      src_mem[{r, c}] = px;
      written[{r, c}] = 1'b1;
      load_cnt++;
    end else begin
      rotated_q.push_back(rotate_next());
      read_cnt++;
    end
  endtask

  // load any source byte the next read touches that was never written, then issue the read
  task automatic read_byte();
    int unsigned       h, r, j;
    logic [ADDR_W-1:0] a;
    h = clamped_height();
    for (j = 0; j < 8; j++) begin
      r = blk_cur * 8 + j;
      a = {ROW_W'(r), col_cur};
      if (r < h && !written[a]) send_item(OP_LOAD, ROW_W'(r), col_cur, 8'($urandom));
    end
    send_item(OP_READ, ROW_W'($urandom), COL_W'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_cnt++;
    case (idx)
      CFG_WIDTH: begin
        width_reg = data[WID_W-1:0];
        rewind_image();
      end
      CFG_HEIGHT: begin
        height_reg = data[HGT_W-1:0];
        rewind_image();
      end
      CFG_STRIP: begin
        strip_reg = data[STRIP_W-1:0];
        rewind_image();
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(OP_LOAD, '1, '1, 8'hFF);
    send_item(OP_LOAD, '0, '0, 8'h00);
    send_item(OP_LOAD, 10'd512, 6'd32, 8'h80);
    send_item(OP_LOAD, 10'd7, 6'd63, 8'h01);
    repeat (2) read_byte();
    wait_idle();
  endtask

  task automatic test_register_limits();
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '0);
    write_reg(CFG_STRIP, '0);
    repeat (18) read_byte();
    wait_idle();
    write_reg(CFG_WIDTH, '1);
    write_reg(CFG_HEIGHT, '1);
    write_reg(CFG_STRIP, '1);
    repeat (4) read_byte();
    wait_idle();
    write_reg(CFG_WIDTH, DATA_W'(MAX_WIDTH_BYTES));
    write_reg(CFG_HEIGHT, DATA_W'(MAX_HEIGHT));
    write_reg(CFG_STRIP, DATA_W'(MAX_WIDTH_BYTES));
    repeat (3) read_byte();
    wait_idle();
    write_reg(CFG_WIDTH, DATA_W'(MAX_WIDTH_BYTES + 1));
    write_reg(CFG_HEIGHT, DATA_W'(MAX_HEIGHT + 1));
    repeat (2) read_byte();
    wait_idle();
    write_reg(CFG_WIDTH, DATA_W'(1));
    write_reg(CFG_HEIGHT, DATA_W'(8));
    write_reg(CFG_STRIP, DATA_W'(MAX_WIDTH_BYTES));
    send_item(OP_LOAD, 10'd0, 6'd5, 8'h5A);
    repeat (16) read_byte();
    wait_idle();
    write_reg(CFG_WIDTH, DATA_W'(3));
    write_reg(CFG_HEIGHT, DATA_W'(17));
    write_reg(CFG_STRIP, DATA_W'(2));
    repeat (30) read_byte();
    wait_idle();
    write_reg(CFG_SPARE, '1);
    repeat (70) read_byte();
    wait_idle();
  endtask

  task automatic test_output_stall();
    write_reg(CFG_WIDTH, DATA_W'(2));
    write_reg(CFG_HEIGHT, DATA_W'(16));
    write_reg(CFG_STRIP, DATA_W'(1));
    hold_req = 1'b1;
    repeat (24) read_byte();
    wait_idle();
  endtask

  task automatic test_random_images();
    int unsigned       phase, n, k, stop_at;
    logic [DATA_W-1:0] wd, hd, sd;
    phase   = 0;
    stop_at = item_cnt + RANDOM_ITEMS;
    while (item_cnt < stop_at) begin
      no_idle = (phase == 3 || phase == 4);
      if ($urandom_range(0, 9) == 0) begin
        wd = DATA_W'($urandom);
        hd = DATA_W'($urandom);
        sd = DATA_W'($urandom);
        n  = $urandom_range(4, 12);
      end else begin
        wd = DATA_W'($urandom_range(1, 6));
        hd = DATA_W'($urandom_range(1, 40));
        sd = DATA_W'($urandom_range(0, 7));
        n  = $urandom_range(20, 70);
      end
      if ($urandom_range(0, 3) != 0) write_reg(CFG_WIDTH, wd);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_HEIGHT, hd);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_STRIP, sd);
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, DATA_W'($urandom));
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < 20) begin
          if ($urandom_range(0, 1) != 0)
            send_item(OP_LOAD, ROW_W'($urandom_range(0, 47)), COL_W'($urandom_range(0, 7)),
                      8'($urandom));
          else
            send_item(OP_LOAD, ROW_W'($urandom), COL_W'($urandom), 8'($urandom));
        end else begin
          read_byte();
        end
      end
      wait_idle();
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        $error("unexpected transfer: rotated_byte %0h", rotated_byte);
        err_cnt++;
      end else begin
        want = rotated_q.pop_front();
        if (rotated_byte !== want.data) begin
          $error("rotated_byte: expected %0h, actual %0h", want.data, rotated_byte);
          err_cnt++;
        end
        if (strip_end !== want.strip_end) begin
          $error("strip_end: expected %0d, actual %0d", want.strip_end, strip_end);
          err_cnt++;
        end
        if (strip_rows !== want.strip_rows) begin
          $error("strip_rows: expected %0d, actual %0d", want.strip_rows, strip_rows);
          err_cnt++;
        end
        if (image_end !== want.image_end) begin
          $error("image_end: expected %0d, actual %0d", want.image_end, image_end);
          err_cnt++;
        end
        if (want.strip_end) strips_seen++;
        if (want.image_end) images_seen++;
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("bitmap_rotate_ccw_strips_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    width_reg  = WID_W'(MAX_WIDTH_BYTES);
    height_reg = HGT_W'(MAX_HEIGHT);
    strip_reg  = STRIP_W'(1);
    rewind_image();
    repeat (2) @(posedge clk);
    test_reset_state();
    test_register_limits();
    test_output_stall();
    test_random_images();
    wait_idle();
    $display("covered %0d loads and %0d rotated reads, %0d strip ends, %0d image ends",
             load_cnt, read_cnt, strips_seen, images_seen);
    $display("over %0d register writes incl. clamped values, plus one long output stall",
             cfg_cnt);
    if (err_cnt == 0) $display("bitmap_rotate_ccw_strips_tb: done, clean");
    else $display("bitmap_rotate_ccw_strips_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/brot_pkg.sv
rtl/brot_ram.sv
rtl/brot_cfg.sv
rtl/brot_engine.sv
rtl/bitmap_rotate_ccw_strips.sv
tb/bitmap_rotate_ccw_strips_tb.sv
